>>> hdl/vgos_pkg.sv
package vgos_pkg;

    localparam int DIM_W       = 5;
    localparam int EXT_W       = 7;
    localparam int LIN_W       = 18;
    localparam int TOT_W       = 19;
    localparam int QUEUE_DEPTH = 2;
    localparam int NUM_DIRS    = 6;

    localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

    localparam logic [2:0] CMD_WRITE  = 3'd0;
    localparam logic [2:0] CMD_ADD    = 3'd1;
    localparam logic [2:0] CMD_REMOVE = 3'd2;
    localparam logic [2:0] CMD_READ   = 3'd3;
    localparam logic [2:0] CMD_NBR    = 3'd4;

    localparam logic [2:0] DIR_POS_Y = 3'd0;
    localparam logic [2:0] DIR_POS_X = 3'd1;
    localparam logic [2:0] DIR_POS_Z = 3'd2;
    localparam logic [2:0] DIR_NEG_X = 3'd3;
    localparam logic [2:0] DIR_NEG_Z = 3'd4;
    localparam logic [2:0] DIR_NEG_Y = 3'd5;

    localparam logic [1:0] REG_DIM_X = 2'd0;
    localparam logic [1:0] REG_DIM_Y = 2'd1;
    localparam logic [1:0] REG_DIM_Z = 2'd2;

    typedef struct packed {
        logic [2:0]  command;
        logic [11:0] cell_index;
        logic [3:0]  cell_x;
        logic [3:0]  cell_y;
        logic [3:0]  cell_z;
        logic [2:0]  direction;
        logic        drawable_flag;
        logic [7:0]  block_type;
    } req_t;

    typedef struct packed {
        logic [7:0] block_value;
        logic       is_drawable;
        logic       out_of_range;
    } rsp_t;

    typedef enum logic [2:0] {
        OP_WRITE,
        OP_ADD,
        OP_REMOVE,
        OP_READ,
        OP_NOP
    } op_t;

    typedef logic signed [5:0] coord_t;

    typedef struct packed {
        op_t         op;
        logic [11:0] index;
        coord_t      x;
        coord_t      y;
        coord_t      z;
        logic        bad;
        logic        flag;
        logic [7:0]  value;
    } work_t;

    typedef struct packed {
        logic [EXT_W-1:0] x;
        logic [EXT_W-1:0] y;
        logic [EXT_W-1:0] z;
    } dims_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic coord_t dir_delta_x(logic [2:0] d);
        coord_t r;
        case (d)
            DIR_POS_X: r = 6'sd1;
            DIR_NEG_X: r = -6'sd1;
            default:   r = 6'sd0;
        endcase
        return r;
    endfunction

    function automatic coord_t dir_delta_y(logic [2:0] d);
        coord_t r;
        case (d)
            DIR_POS_Y: r = 6'sd1;
            DIR_NEG_Y: r = -6'sd1;
            default:   r = 6'sd0;
        endcase
        return r;
    endfunction

    function automatic coord_t dir_delta_z(logic [2:0] d);
        coord_t r;
        case (d)
            DIR_POS_Z: r = 6'sd1;
            DIR_NEG_Z: r = -6'sd1;
            default:   r = 6'sd0;
        endcase
        return r;
    endfunction

endpackage

>>> hdl/voxel_grid_occupancy_store.sv
// Voxel grid store: a type byte and a drawable bit per cell of a grid of up to
// MAX_CELLS cells, addressed z*dim_y*dim_x + x*dim_y + y, with extents set over
// the APB port (0 is taken as 1, values above MAX_EXTENT as MAX_EXTENT). Every
// request beat gives exactly one response beat. After reset a clearing pass
// zeroes all MAX_CELLS cells of the memory while req_ready stays low. Requests
// go into a two-entry queue and are run one at a time by a sequencer around a
// single-port cell memory: write, add, unused commands and any out-of-range
// request go through multiply, execute and output; in-grid read cell and read
// neighbour add a memory read, and in-grid remove a pass over the six face
// neighbours, each with a bounds check and, when it lies in the grid, a
// read-modify-write. The response may then wait for rsp_ready.
module voxel_grid_occupancy_store
    import vgos_pkg::*;
#(
    parameter int MAX_CELLS  = 4096,
    parameter int MAX_EXTENT = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_t        rsp
);

    logic [DIM_W-1:0] dim_x_reg;
    logic [DIM_W-1:0] dim_y_reg;
    logic [DIM_W-1:0] dim_z_reg;
    dims_t            dims;
    logic             cfg_write;
    logic             clearing;
    logic             q_push;
    logic             q_pop;
    work_t            q_in;
    work_t            q_head;
    q_status_t        q_status;

    function automatic logic [EXT_W-1:0] eff_dim(logic [DIM_W-1:0] d);
        logic [EXT_W-1:0] r;
        if (d == '0)
        begin
            r = EXT_W'(1);
        end
        else if (EXT_W'(d) > EXT_W'(MAX_EXTENT))
        begin
            r = EXT_W'(MAX_EXTENT);
        end
        else
        begin
            r = EXT_W'(d);
        end
        return r;
    endfunction

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_x_reg <= DIM_RESET;
            dim_y_reg <= DIM_RESET;
            dim_z_reg <= DIM_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_DIM_X: dim_x_reg <= pwdata[DIM_W-1:0];
                REG_DIM_Y: dim_y_reg <= pwdata[DIM_W-1:0];
                REG_DIM_Z: dim_z_reg <= pwdata[DIM_W-1:0];
                default:   dim_x_reg <= dim_x_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_DIM_X: prdata = 32'(dim_x_reg);
            REG_DIM_Y: prdata = 32'(dim_y_reg);
            REG_DIM_Z: prdata = 32'(dim_z_reg);
            default:   prdata = '0;
        endcase
    end

    assign dims.x = eff_dim(dim_x_reg);
    assign dims.y = eff_dim(dim_y_reg);
    assign dims.z = eff_dim(dim_z_reg);

    vgos_front u_front (
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .clearing  (clearing),
        .q_status  (q_status),
        .push      (q_push),
        .push_data (q_in)
    );

    vgos_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .status    (q_status)
    );

    vgos_back #(
        .MAX_CELLS (MAX_CELLS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .dims      (dims),
        .q_status  (q_status),
        .q_head    (q_head),
        .pop       (q_pop),
        .clearing  (clearing),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    a_clear_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !req_ready)
        else $error("request taken during clearing pass");

    a_no_queue_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_status.full)
        else $error("push into full queue");

    a_no_queue_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("pop from empty queue");

    a_oor_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.out_of_range) |-> (rsp.block_value == 8'd0 && !rsp.is_drawable))
        else $error("out-of-range beat carries data");

endmodule

>>> hdl/vgos_front.sv
module vgos_front
    import vgos_pkg::*;
(
    input  logic      req_valid,
    output logic      req_ready,
    input  req_t      req,
    input  logic      clearing,
    input  q_status_t q_status,
    output logic      push,
    output work_t     push_data
);

    coord_t base_x;
    coord_t base_y;
    coord_t base_z;

    assign req_ready = !q_status.full && !clearing;
    assign push      = req_valid && req_ready;

    assign base_x = coord_t'({2'b00, req.cell_x});
    assign base_y = coord_t'({2'b00, req.cell_y});
    assign base_z = coord_t'({2'b00, req.cell_z});

    always_comb
    begin
        push_data.index = req.cell_index;
        push_data.flag  = req.drawable_flag;
        push_data.value = req.block_type;
        push_data.x     = base_x;
        push_data.y     = base_y;
        push_data.z     = base_z;
        push_data.bad   = 1'b0;
        case (req.command)
            CMD_WRITE:  push_data.op = OP_WRITE;
            CMD_ADD:    push_data.op = OP_ADD;
            CMD_REMOVE: push_data.op = OP_REMOVE;
            CMD_READ:   push_data.op = OP_READ;
            CMD_NBR:
            begin
                push_data.op  = OP_READ;
                push_data.bad = req.direction >= 3'(NUM_DIRS);
                push_data.x   = base_x + dir_delta_x(req.direction);
                push_data.y   = base_y + dir_delta_y(req.direction);
                push_data.z   = base_z + dir_delta_z(req.direction);
            end
            default:    push_data.op = OP_NOP;
        endcase
    end

endmodule

>>> hdl/vgos_queue.sv
module vgos_queue
    import vgos_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  work_t     push_data,
    input  logic      pop,
    output work_t     head,
    output q_status_t status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    work_t           entries_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head         = entries_reg[rd_ptr_reg];
    assign status.full  = count_reg == CW'(DEPTH);
    assign status.empty = count_reg == '0;

endmodule

>>> hdl/vgos_back.sv
module vgos_back
    import vgos_pkg::*;
#(
    parameter int MAX_CELLS = 4096
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  dims_t     dims,
    input  q_status_t q_status,
    input  work_t     q_head,
    output logic      pop,
    output logic      clearing,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_t      rsp
);

    localparam int AW     = $clog2(MAX_CELLS);
    localparam int WORD_W = 9;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_EXEC,
        S_READ,
        S_NB_ADDR,
        S_NB_UPD,
        S_OUT
    } state_t;

    state_t            state_reg;
    logic [AW-1:0]     clr_addr_reg;
    work_t             cur_reg;
    logic [LIN_W-1:0]  dxy_reg;
    logic [LIN_W-1:0]  xdy_reg;
    logic [LIN_W-1:0]  lin_reg;
    logic [TOT_W-1:0]  total_reg;
    logic [2:0]        nb_reg;
    logic [AW-1:0]     nb_addr_reg;
    rsp_t              res_reg;
    logic              rsp_valid_reg;
    rsp_t              rsp_reg;
    logic [WORD_W-1:0] rdata_reg;

    logic [WORD_W-1:0] cell_mem [MAX_CELLS];

    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [WORD_W-1:0] mem_wdata;
    logic              coord_ok;
    logic              cell_ok;
    logic              idx_ok;
    logic              nb_ok;
    logic [LIN_W-1:0]  nb_lin;
    logic              nb_last;

    function automatic logic in_ext(coord_t c, logic [EXT_W-1:0] d);
        return !c[5] && (EXT_W'(c[4:0]) < d);
    endfunction

    assign coord_ok = !cur_reg.bad && in_ext(cur_reg.x, dims.x)
                      && in_ext(cur_reg.y, dims.y) && in_ext(cur_reg.z, dims.z);
    assign cell_ok  = coord_ok && (lin_reg < LIN_W'(MAX_CELLS));
    assign idx_ok   = (TOT_W'(cur_reg.index) < total_reg)
                      && (LIN_W'(cur_reg.index) < LIN_W'(MAX_CELLS));
    assign nb_last  = nb_reg == DIR_NEG_Y;

    // face neighbours of an in-grid cell; coordinates are known nonnegative here
    always_comb
    begin
        nb_ok  = 1'b0;
        nb_lin = lin_reg;
        case (nb_reg)
            DIR_POS_Y:
            begin
                nb_ok  = (EXT_W'(cur_reg.y[4:0]) + EXT_W'(1)) < dims.y;
                nb_lin = lin_reg + LIN_W'(1);
            end
            DIR_POS_X:
            begin
                nb_ok  = (EXT_W'(cur_reg.x[4:0]) + EXT_W'(1)) < dims.x;
                nb_lin = lin_reg + LIN_W'(dims.y);
            end
            DIR_POS_Z:
            begin
                nb_ok  = (EXT_W'(cur_reg.z[4:0]) + EXT_W'(1)) < dims.z;
                nb_lin = lin_reg + dxy_reg;
            end
            DIR_NEG_X:
            begin
                nb_ok  = cur_reg.x != '0;
                nb_lin = lin_reg - LIN_W'(dims.y);
            end
            DIR_NEG_Z:
            begin
                nb_ok  = cur_reg.z != '0;
                nb_lin = lin_reg - dxy_reg;
            end
            DIR_NEG_Y:
            begin
                nb_ok  = cur_reg.y != '0;
                nb_lin = lin_reg - LIN_W'(1);
            end
            default:
            begin
                nb_ok  = 1'b0;
                nb_lin = lin_reg;
            end
        endcase
        nb_ok = nb_ok && (nb_lin < LIN_W'(MAX_CELLS));
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = AW'(lin_reg);
        mem_wdata = '0;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_addr_reg;
            end
            S_EXEC:
            begin
                case (cur_reg.op)
                    OP_WRITE:
                    begin
                        mem_addr  = AW'(cur_reg.index);
                        mem_we    = idx_ok;
                        mem_wdata = {cur_reg.value, cur_reg.flag};
                    end
                    OP_ADD:
                    begin
                        mem_we    = cell_ok;
                        mem_wdata = {8'd1, 1'b1};
                    end
                    OP_REMOVE:
                    begin
                        mem_we    = cell_ok;
                        mem_wdata = '0;
                    end
                    default:
                    begin
                        mem_we = 1'b0;
                    end
                endcase
            end
            S_NB_ADDR:
            begin
                mem_addr = AW'(nb_lin);
            end
            S_NB_UPD:
            begin
                mem_addr  = nb_addr_reg;
                mem_we    = rdata_reg[8:1] != 8'd0;
                mem_wdata = {rdata_reg[8:1], 1'b1};
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= cell_mem[mem_addr];
    end

    assign pop       = (state_reg == S_IDLE) && !q_status.empty;
    assign clearing  = state_reg == S_CLEAR;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            rsp_valid_reg <= 1'b0;
            nb_reg        <= DIR_POS_Y;
            cur_reg       <= '0;
            dxy_reg       <= '0;
            xdy_reg       <= '0;
            lin_reg       <= '0;
            total_reg     <= '0;
            nb_addr_reg   <= '0;
            res_reg       <= '0;
            rsp_reg       <= '0;
        end
        else
        begin
            if (rsp_valid_reg && rsp_ready && state_reg != S_OUT)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == AW'(MAX_CELLS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (!q_status.empty)
                    begin
                        cur_reg   <= q_head;
                        state_reg <= S_MUL1;
                    end
                end
                S_MUL1:
                begin
                    dxy_reg   <= LIN_W'(dims.y) * LIN_W'(dims.x);
                    xdy_reg   <= LIN_W'(cur_reg.x[4:0]) * LIN_W'(dims.y);
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    lin_reg   <= LIN_W'(cur_reg.z[4:0] * dxy_reg) + xdy_reg
                                 + LIN_W'(cur_reg.y[4:0]);
                    total_reg <= TOT_W'(dxy_reg * dims.z);
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    case (cur_reg.op)
                        OP_WRITE:
                        begin
                            res_reg   <= rsp_t'{8'd0, idx_ok & cur_reg.flag, !idx_ok};
                            state_reg <= S_OUT;
                        end
                        OP_ADD:
                        begin
                            res_reg   <= rsp_t'{8'd0, cell_ok, !cell_ok};
                            state_reg <= S_OUT;
                        end
                        OP_REMOVE:
                        begin
                            res_reg   <= rsp_t'{8'd0, 1'b0, !cell_ok};
                            nb_reg    <= DIR_POS_Y;
                            state_reg <= cell_ok ? S_NB_ADDR : S_OUT;
                        end
                        OP_READ:
                        begin
                            res_reg   <= rsp_t'{8'd0, 1'b0, !cell_ok};
                            state_reg <= cell_ok ? S_READ : S_OUT;
                        end
                        default:
                        begin
                            res_reg   <= rsp_t'{8'd0, 1'b0, 1'b0};
                            state_reg <= S_OUT;
                        end
                    endcase
                end
                S_READ:
                begin
                    res_reg   <= rsp_t'{rdata_reg[8:1], rdata_reg[0], 1'b0};
                    state_reg <= S_OUT;
                end
                S_NB_ADDR:
                begin
                    nb_addr_reg <= AW'(nb_lin);
                    if (nb_ok)
                    begin
                        state_reg <= S_NB_UPD;
                    end
                    else if (nb_last)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        nb_reg <= nb_reg + 1'b1;
                    end
                end
                S_NB_UPD:
                begin
                    if (nb_last)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        nb_reg    <= nb_reg + 1'b1;
                        state_reg <= S_NB_ADDR;
                    end
                end
                S_OUT:
                begin
                    if (!rsp_valid_reg || rsp_ready)
                    begin
                        rsp_reg       <= res_reg;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import vgos_pkg::*;

    localparam int GRID_CELLS      = 4096;
    localparam int EXTENT_CAP      = 16;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 163;
    localparam int SETTLE_CYCLES   = 30;

    localparam logic [2:0] CMD_SPARE_5 = 3'd5;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;
    localparam logic [2:0] DIR_SPARE_6 = 3'd6;
    localparam logic [2:0] DIR_SPARE_7 = 3'd7;

    typedef struct {
        req_t beat;
        bit   known;
        rsp_t want;
    } script_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        req_valid;
    logic        req_ready;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_ready;
    rsp_t        rsp;

    voxel_grid_occupancy_store dut (.*);

    bit [7:0]    grid_type [GRID_CELLS];
    bit          grid_mark [GRID_CELLS];
    logic [4:0]  dim_now [3];
    int          win_lo [3];
    int          win_span [3];
    rsp_t        pending_rsp [$];
    script_row_t script [$];
    int          err_count;
    int          sent_count;
    int          beat_count;
    int          cycle_count;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int extent(logic [4:0] d);
        if (d == 0)
            return 1;
        if (d > EXTENT_CAP)
            return EXTENT_CAP;
        return int'(d);
    endfunction

    function automatic int cell_slot(int x, int y, int z);
        int ex;
        int ey;
        int ez;
        int idx;
        ex = extent(dim_now[REG_DIM_X]);
        ey = extent(dim_now[REG_DIM_Y]);
        ez = extent(dim_now[REG_DIM_Z]);
        if (x < 0 || y < 0 || z < 0 || x >= ex || y >= ey || z >= ez)
            return -1;
        idx = z * ey * ex + x * ey + y;
        if (idx >= GRID_CELLS)
            return -1;
        return idx;
    endfunction

    function automatic void expose(int x, int y, int z);
        int slot;
        slot = cell_slot(x, y, z);
        if (slot >= 0 && grid_type[slot] != 0)
            grid_mark[slot] = 1'b1;
    endfunction

    function automatic rsp_t grid_step(req_t r);
        rsp_t o;
        int   slot;
        int   x;
        int   y;
        int   z;
        int   total;
        o = '0;
        x = int'(r.cell_x);
        y = int'(r.cell_y);
        z = int'(r.cell_z);
        case (r.command)
            CMD_WRITE:
            begin
                total = extent(dim_now[REG_DIM_X]) * extent(dim_now[REG_DIM_Y])
                        * extent(dim_now[REG_DIM_Z]);
                if (int'(r.cell_index) >= total)
                    o.out_of_range = 1'b1;
                else
                begin
                    grid_type[r.cell_index] = r.block_type;
                    grid_mark[r.cell_index] = r.drawable_flag;
                    o.is_drawable = r.drawable_flag;
                end
            end
            CMD_ADD:
            begin
                slot = cell_slot(x, y, z);
                if (slot < 0)
                    o.out_of_range = 1'b1;
                else
                begin
                    grid_type[slot] = 8'd1;
                    grid_mark[slot] = 1'b1;
                    o.is_drawable = 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                slot = cell_slot(x, y, z);
                if (slot < 0)
                    o.out_of_range = 1'b1;
                else
                begin
                    grid_type[slot] = 8'd0;
                    grid_mark[slot] = 1'b0;
                    expose(x, y, z + 1);
                    expose(x + 1, y, z);
                    expose(x, y, z - 1);
                    expose(x - 1, y, z);
                    expose(x, y + 1, z);
                    expose(x, y - 1, z);
                end
            end
            CMD_READ, CMD_NBR:
            begin
                if (r.command == CMD_NBR)
                begin
                    case (r.direction)
                        DIR_POS_Y: y = y + 1;
                        DIR_POS_X: x = x + 1;
                        DIR_POS_Z: z = z + 1;
                        DIR_NEG_X: x = x - 1;
                        DIR_NEG_Z: z = z - 1;
                        DIR_NEG_Y: y = y - 1;
                        default:   x = -1;
                    endcase
                end
                slot = cell_slot(x, y, z);
                if (slot < 0)
                    o.out_of_range = 1'b1;
                else
                begin
                    o.block_value = grid_type[slot];
                    o.is_drawable = grid_mark[slot];
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic void script_row(logic [2:0] cmd, int idx, int x, int y, int z,
                                       logic [2:0] dir, bit flag, int bt, bit known,
                                       int val, bit draw, bit oor);
        script_row_t s;
        s.beat.command       = cmd;
        s.beat.cell_index    = 12'(idx);
        s.beat.cell_x        = 4'(x);
        s.beat.cell_y        = 4'(y);
        s.beat.cell_z        = 4'(z);
        s.beat.direction     = dir;
        s.beat.drawable_flag = flag;
        s.beat.block_type    = 8'(bt);
        s.known              = known;
        s.want.block_value   = 8'(val);
        s.want.is_drawable   = draw;
        s.want.out_of_range  = oor;
        script.push_back(s);
    endfunction

    function automatic logic [3:0] pick_coord(int axis);
        if ($urandom_range(99) < 12)
            return 4'($urandom);
        return 4'(win_lo[axis] + $urandom_range(0, win_span[axis] - 1));
    endfunction

    function automatic req_t random_beat();
        req_t r;
        int   p;
        int   ex;
        int   ey;
        int   ez;
        ex = extent(dim_now[REG_DIM_X]);
        ey = extent(dim_now[REG_DIM_Y]);
        ez = extent(dim_now[REG_DIM_Z]);
        p = $urandom_range(99);
        if (p < 12)
            r.command = CMD_WRITE;
        else if (p < 35)
            r.command = CMD_ADD;
        else if (p < 55)
            r.command = CMD_REMOVE;
        else if (p < 72)
            r.command = CMD_READ;
        else if (p < 94)
            r.command = CMD_NBR;
        else
            r.command = 3'($urandom_range(CMD_SPARE_5, CMD_SPARE_7));
        r.cell_x = pick_coord(0);
        r.cell_y = pick_coord(1);
        r.cell_z = pick_coord(2);
        p = $urandom_range(99);
        if (p < 50)
            r.cell_index = 12'(int'(r.cell_z) * ey * ex + int'(r.cell_x) * ey
                               + int'(r.cell_y));
        else if (p < 85)
            r.cell_index = 12'($urandom_range(0, ex * ey * ez - 1));
        else
            r.cell_index = 12'($urandom);
        if ($urandom_range(99) < 92)
            r.direction = 3'($urandom_range(DIR_POS_Y, DIR_NEG_Y));
        else
            r.direction = 3'($urandom_range(DIR_SPARE_6, DIR_SPARE_7));
        r.drawable_flag = 1'($urandom);
        r.block_type = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom);
        return r;
    endfunction

    task automatic apb_write(logic [1:0] reg_id, logic [4:0] value);
        logic [31:0] w;
        w = $urandom;
        w[4:0] = value;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_id, 2'b00};
        pwdata  <= w;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        dim_now[reg_id] = value;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata[4:0] !== value)
        begin
            $error("prdata expected %0d got %0d", value, prdata[4:0]);
            err_count++;
        end
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic offer(req_t r, bit known, rsp_t want, bit gaps);
        rsp_t guess;
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        guess = grid_step(r);
        pending_rsp.push_back(known ? want : guess);
        sent_count++;
        if (gaps && $urandom_range(99) < 22)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 22);
        end
    endtask

    task automatic settle();
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // response side: check each beat, then pick next rsp_ready
    initial
    begin
        int   hold;
        bit   held;
        rsp_t want;
        hold = 0;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
            begin
                beat_count++;
                if (pending_rsp.size() == 0)
                begin
                    $error("response beat with nothing expected");
                    err_count++;
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    if (rsp.block_value !== want.block_value)
                    begin
                        $error("block_value expected %0d got %0d",
                               want.block_value, rsp.block_value);
                        err_count++;
                    end
                    if (rsp.is_drawable !== want.is_drawable)
                    begin
                        $error("is_drawable expected %0d got %0d",
                               want.is_drawable, rsp.is_drawable);
                        err_count++;
                    end
                    if (rsp.out_of_range !== want.out_of_range)
                    begin
                        $error("out_of_range expected %0d got %0d",
                               want.out_of_range, rsp.out_of_range);
                        err_count++;
                    end
                end
            end
            if (hold > 0)
            begin
                hold--;
                rsp_ready <= 1'b0;
            end
            else if (!held && beat_count == 400)
            begin
                held = 1'b1;
                hold = 300;
                rsp_ready <= 1'b0;
            end
            else if (beat_count >= 500 && beat_count < 800)
                rsp_ready <= 1'b1;
            else
                rsp_ready <= ($urandom_range(99) >= 22);
        end
    end

    initial
    begin
        logic [4:0] d [3];
        rsp_t       none;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        req_valid   = 1'b0;
        req         = '0;
        rsp_ready   = 1'b0;
        none        = '0;
        err_count   = 0;
        sent_count  = 0;
        beat_count  = 0;
        cycle_count = 0;
        dim_now[REG_DIM_X] = DIM_RESET;
        dim_now[REG_DIM_Y] = DIM_RESET;
        dim_now[REG_DIM_Z] = DIM_RESET;

        script_row(CMD_READ,      0,  0,  0,  0, DIR_POS_Y,   0,   0, 1,   0, 0, 0);
        script_row(CMD_WRITE,  4095,  0,  0,  0, DIR_POS_Y,   1, 255, 1,   0, 1, 0);
        script_row(CMD_READ,      0, 15, 15, 15, DIR_POS_Y,   0,   0, 1, 255, 1, 0);
        script_row(CMD_NBR,       0, 15, 15, 14, DIR_POS_Z,   0,   0, 1, 255, 1, 0);
        script_row(CMD_NBR,       0, 15, 15, 15, DIR_POS_X,   0,   0, 1,   0, 0, 1);
        script_row(CMD_NBR,       0,  0,  0,  0, DIR_SPARE_6, 0,   0, 1,   0, 0, 1);
        script_row(CMD_WRITE,     0,  0,  0,  0, DIR_POS_Y,   0,  90, 1,   0, 0, 0);
        script_row(CMD_READ,      0,  0,  0,  0, DIR_POS_Y,   0,   0, 1,  90, 0, 0);
        script_row(CMD_ADD,       0,  1,  1,  1, DIR_POS_Y,   0,   0, 1,   0, 1, 0);
        script_row(CMD_ADD,       0,  2,  1,  1, DIR_POS_Y,   0,   0, 0,   0, 0, 0);
        script_row(CMD_ADD,       0,  0,  1,  1, DIR_POS_Y,   0,   0, 0,   0, 0, 0);
        script_row(CMD_ADD,       0,  1,  2,  1, DIR_POS_Y,   0,   0, 0,   0, 0, 0);
        script_row(CMD_ADD,       0,  1,  0,  1, DIR_POS_Y,   0,   0, 0,   0, 0, 0);
        script_row(CMD_ADD,       0,  1,  1,  2, DIR_POS_Y,   0,   0, 0,   0, 0, 0);
        script_row(CMD_ADD,       0,  1,  1,  0, DIR_POS_Y,   0,   0, 0,   0, 0, 0);
        script_row(CMD_WRITE,   289,  0,  0,  0, DIR_POS_Y,   0,   7, 1,   0, 0, 0);
        script_row(CMD_WRITE,   272,  0,  0,  0, DIR_POS_Y,   0,   3, 1,   0, 0, 0);
        script_row(CMD_REMOVE,    0,  1,  1,  1, DIR_POS_Y,   0,   0, 1,   0, 0, 0);
        script_row(CMD_NBR,       0,  1,  1,  1, DIR_POS_X,   0,   0, 1,   7, 1, 0);
        script_row(CMD_NBR,       0,  1,  1,  1, DIR_NEG_Y,   0,   0, 1,   3, 1, 0);
        script_row(CMD_NBR,       0,  1,  1,  1, DIR_POS_Y,   0,   0, 0,   0, 0, 0);
        script_row(CMD_NBR,       0,  1,  1,  1, DIR_NEG_X,   0,   0, 0,   0, 0, 0);
        script_row(CMD_NBR,       0,  1,  1,  1, DIR_NEG_Z,   0,   0, 0,   0, 0, 0);
        script_row(CMD_SPARE_5,  12,  3,  4,  5, DIR_POS_Y,   1, 200, 1,   0, 0, 0);
        script_row(CMD_SPARE_7,  12,  3,  4,  5, DIR_POS_Y,   1, 200, 1,   0, 0, 0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
            offer(script[i].beat, script[i].known, script[i].want, 1'b1);
        req_valid <= 1'b0;
        settle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:       d = '{5'd31, 5'd31, 5'd31};
                1:       d = '{5'd0, 5'd0, 5'd0};
                2:       d = '{5'd4, 5'd3, 5'd2};
                3:       d = '{5'd16, 5'd1, 5'd16};
                4:       d = '{5'd1, 5'd16, 5'd1};
                5:       d = '{5'd3, 5'd3, 5'd3};
                default:
                begin
                    foreach (d[a])
                        d[a] = ($urandom_range(9) == 0) ? 5'($urandom)
                                                        : 5'($urandom_range(1, 16));
                end
            endcase
            apb_write(REG_DIM_X, d[0]);
            apb_write(REG_DIM_Y, d[1]);
            apb_write(REG_DIM_Z, d[2]);
            for (int a = 0; a < 3; a++)
            begin
                win_span[a] = (extent(d[a]) < 4) ? extent(d[a]) : 4;
                win_lo[a] = $urandom_range(0, extent(d[a]) - win_span[a]);
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (ph == 5 && n == 80)
                begin
                    req_valid <= 1'b0;
                    settle();
                end
                offer(random_beat(), 1'b0, none, !(sent_count >= 500 && sent_count < 800));
            end
            req_valid <= 1'b0;
            settle();
        end

        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
